// ----- src/dct_pkg.sv -----
`default_nettype none
package dct_pkg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_LD,
        S_MUL,
        S_ACC,
        S_OUT
    } state_t;

    localparam logic [31:0] COS_HI [9] = '{
        32'd1073741824, 32'd1053110176, 32'd991988094, 32'd892783698,
        32'd759250125, 32'd596538995, 32'd410903207, 32'd209476638, 32'd0
    };
    localparam logic [31:0] INV_SQRT2_HI = 32'd759250125;
    localparam int HI_FRAC_BITS = 30;

    function automatic logic signed [31:0] kcoef(input logic [2:0] u, input logic [2:0] m,
                                                 input int frac);
        logic [6:0]  k;
        logic [4:0]  r;
        logic [3:0]  idx;
        logic        neg;
        logic [31:0] hi;
        logic [31:0] mag;
        int          sh;
        k   = 7'((2 * int'(m) + 1) * int'(u));
        r   = k[4:0];
        neg = 1'b0;
        idx = 4'd0;
        if (u == 3'd0)
        begin
            hi = INV_SQRT2_HI;
        end
        else
        begin
            if (r > 5'd16)
            begin
                r = 5'(6'd32 - {1'b0, r});
            end
            if (r > 5'd8)
            begin
                neg = 1'b1;
                idx = 4'(5'd16 - r);
            end
            else
            begin
                idx = r[3:0];
            end
            hi = COS_HI[idx];
        end
        sh  = HI_FRAC_BITS - frac;
        mag = (hi + (32'd1 << (sh - 1))) >> sh;
        return neg ? -mag : mag;
    endfunction

endpackage
`default_nettype wire

// ----- src/dct_ram.sv -----
`default_nettype none
module dct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// ----- src/dct8x8_forward.sv -----
// Sequence: the first coefficient follows the 64th accepted pixel after 512 row terms and
//   8 column terms, each computed by the single shift-add multiplier, which walks one
//   weight or pixel bit per cycle; each later coefficient takes 8 further column terms.
// A block is 64 pixel writes, 1024 terms and 64 coefficient strobes; no new pixels are
//   accepted while busy, so a new block starts only after the last coefficient.
// Results are strobed for one cycle; the receiver cannot stall.
// Reset clears the fill count and control, sets byte mode; the pixel store is not cleared.
`default_nettype none
module dct8x8_forward #(
    parameter int COEF_FRAC_BITS = 14
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [7:0]         pixel_value,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic               cfg_data,
    output logic                    result_valid,
    output logic signed [11:0]      coefficient,
    output logic [5:0]              freq_index,
    output logic                    last_of_block
);

    localparam int KW = COEF_FRAC_BITS + 2;
    localparam int CW = COEF_FRAC_BITS + 12;
    localparam int AW = 2 * COEF_FRAC_BITS + 16;
    localparam int BW = $clog2(KW);
    localparam int SH = 2 * COEF_FRAC_BITS + 2;

    dct_pkg::state_t state_reg, state_next;
    logic [5:0]  fill_reg, fill_next;
    logic [5:0]  o_reg, o_next;
    logic [2:0]  t_reg, t_next;
    logic [BW-1:0] b_reg, b_next;
    logic        st_reg, st_next;
    logic        mode_reg;
    logic [KW-1:0] ser_reg, ser_next;
    logic signed [AW-1:0] mc_reg, mc_next;
    logic signed [AW-1:0] part_reg, part_next;
    logic signed [AW-1:0] acc_reg, acc_next;

    logic        accept;
    logic        pix_we;
    logic [7:0]  pix_rd;
    logic [5:0]  pix_raddr;
    logic        cs_we;
    logic [CW-1:0] cs_rd;
    logic [5:0]  cs_raddr;
    logic [2:0]  ku;
    logic signed [31:0] k_full;
    logic signed [KW-1:0] k_val;
    logic signed [AW-1:0] addend;

    logic [AW-1:0] mag;
    logic [AW-1:0] rnd;
    logic signed [15:0] sval;

    assign accept    = start && !busy;
    assign busy      = (state_reg != dct_pkg::S_IDLE);
    assign cfg_ready = !busy;
    assign pix_we    = accept;
    assign pix_raddr = {t_reg, o_reg[2:0]};
    assign cs_raddr  = {o_reg[5:3], t_reg};
    assign ku        = st_reg ? o_reg[2:0] : o_reg[5:3];
    assign k_full    = dct_pkg::kcoef(ku, t_reg, COEF_FRAC_BITS);
    assign k_val     = k_full[KW-1:0];
    assign addend    = ser_reg[KW-1] ? mc_reg : '0;

    dct_ram #(.WIDTH(8), .DEPTH(64)) u_pix_ram (
        .clk   (clk),
        .we    (pix_we),
        .waddr (fill_reg),
        .wdata (pixel_value),
        .raddr (pix_raddr),
        .rdata (pix_rd)
    );

    dct_ram #(.WIDTH(CW), .DEPTH(64)) u_col_ram (
        .clk   (clk),
        .we    (cs_we),
        .waddr (o_reg),
        .wdata (acc_next[CW-1:0]),
        .raddr (cs_raddr),
        .rdata (cs_rd)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dct_pkg::S_IDLE;
            fill_reg  <= '0;
            o_reg     <= '0;
            t_reg     <= '0;
            b_reg     <= '0;
            st_reg    <= 1'b0;
            mode_reg  <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            o_reg     <= o_next;
            t_reg     <= t_next;
            b_reg     <= b_next;
            st_reg    <= st_next;
            if (cfg_valid && cfg_ready)
            begin
                mode_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ser_reg  <= ser_next;
        mc_reg   <= mc_next;
        part_reg <= part_next;
        acc_reg  <= acc_next;
    end

    always_comb
    begin
        state_next = state_reg;
        fill_next  = fill_reg;
        o_next     = o_reg;
        t_next     = t_reg;
        b_next     = b_reg;
        st_next    = st_reg;
        ser_next   = ser_reg;
        mc_next    = mc_reg;
        part_next  = part_reg;
        acc_next   = acc_reg;
        cs_we      = 1'b0;
        unique case (state_reg)
            dct_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    fill_next = fill_reg + 6'd1;
                    if (fill_reg == 6'd63)
                    begin
                        state_next = dct_pkg::S_RD;
                        o_next     = '0;
                        t_next     = '0;
                        st_next    = 1'b0;
                    end
                end
            end
            dct_pkg::S_RD:
            begin
                state_next = dct_pkg::S_LD;
            end
            dct_pkg::S_LD:
            begin
                if (st_reg)
                begin
                    ser_next = k_val;
                    mc_next  = {{(AW-CW){cs_rd[CW-1]}}, cs_rd};
                end
                else
                begin
                    ser_next = {{(KW-8){1'b0}}, pix_rd};
                    mc_next  = {{(AW-KW){k_val[KW-1]}}, k_val};
                end
                b_next     = '0;
                state_next = dct_pkg::S_MUL;
            end
            dct_pkg::S_MUL:
            begin
                if (b_reg == '0)
                begin
                    part_next = -addend;
                end
                else
                begin
                    part_next = (part_reg <<< 1) + addend;
                end
                ser_next = ser_reg << 1;
                b_next   = b_reg + BW'(1);
                if (b_reg == BW'(KW - 1))
                begin
                    state_next = dct_pkg::S_ACC;
                end
            end
            dct_pkg::S_ACC:
            begin
                acc_next = (t_reg == 3'd0) ? part_reg : acc_reg + part_reg;
                t_next   = t_reg + 3'd1;
                if (t_reg != 3'd7)
                begin
                    state_next = dct_pkg::S_RD;
                end
                else if (st_reg)
                begin
                    state_next = dct_pkg::S_OUT;
                end
                else
                begin
                    cs_we      = 1'b1;
                    o_next     = o_reg + 6'd1;
                    state_next = dct_pkg::S_RD;
                    if (o_reg == 6'd63)
                    begin
                        st_next = 1'b1;
                    end
                end
            end
            dct_pkg::S_OUT:
            begin
                o_next = o_reg + 6'd1;
                if (o_reg == 6'd63)
                begin
                    state_next = dct_pkg::S_IDLE;
                end
                else
                begin
                    state_next = dct_pkg::S_RD;
                end
            end
            default:
            begin
                state_next = dct_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        mag  = acc_reg[AW-1] ? AW'(-acc_reg) : AW'(acc_reg);
        rnd  = (mag + (AW'(1) << (SH - 1))) >> SH;
        sval = acc_reg[AW-1] ? -$signed({2'b00, rnd[13:0]}) : $signed({2'b00, rnd[13:0]});
        if (mode_reg)
        begin
            if (sval < 16'sd0)
            begin
                coefficient = 12'sd0;
            end
            else if (sval > 16'sd255)
            begin
                coefficient = 12'sd255;
            end
            else
            begin
                coefficient = sval[11:0];
            end
        end
        else
        begin
            if (sval < -16'sd2048)
            begin
                coefficient = -12'sd2048;
            end
            else if (sval > 16'sd2047)
            begin
                coefficient = 12'sd2047;
            end
            else
            begin
                coefficient = sval[11:0];
            end
        end
    end

    assign result_valid  = (state_reg == dct_pkg::S_OUT);
    assign freq_index    = o_reg;
    assign last_of_block = result_valid && (o_reg == 6'd63);

    a_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> busy)
        else $error("result strobe while idle");

    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        last_of_block |=> !busy)
        else $error("still busy after last coefficient");

    a_fill_hold: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> $stable(fill_reg))
        else $error("fill count moved during compute");

    a_mode_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && mode_reg) |-> !coefficient[11])
        else $error("negative coefficient in byte mode");

endmodule
`default_nettype wire
